// ===== src/rcpi_pkg.sv =====
`timescale 1ns / 1ps
package rcpi_pkg;

	localparam int EXP_TABLE_DEPTH = 256;
	localparam int IDX_W  = $clog2(EXP_TABLE_DEPTH);
	localparam int RIDX_W = $clog2(EXP_TABLE_DEPTH + 1);

	localparam logic [24:0] LOG2E_Q24 = 25'd24204406;
	localparam logic [33:0] ONE_Q16   = 34'd65536;

	localparam logic [23:0] DECAY_RATE_RST = 24'd838861;
	localparam logic [16:0] VOLT_PER_PHOTON_RST = 17'h1FE70; // -400

	// register indexes on the config port
	localparam logic REG_DECAY_RATE = 1'b0;
	localparam logic REG_VOLT_PER_PHOTON = 1'b1;

	typedef logic [EXP_TABLE_DEPTH-1:0][15:0] exp_tab_t;

	// sequencer commands to the datapath
	typedef struct packed {
		logic accept;
		logic first;
		logic load_origin;
		logic step_dt;
		logic step_log;
		logic step_exp;
		logic step_chg;
		logic step_vmul;
		logic load_result;
	} cmd_t;

	function automatic logic [63:0] isqrt64(logic [63:0] v_in);
		logic [63:0] v;
		logic [63:0] res;
		logic [63:0] bt;
		v = v_in;
		res = '0;
		bt = 64'd1 << 62;
		for (int s = 0; s < 32; s++) begin
			if (v >= res + bt) begin
				v = v - (res + bt);
				res = (res >> 1) + bt;
			end else begin
				res = res >> 1;
			end
			bt = bt >> 2;
		end
		return res;
	endfunction

	// entry i = 2^(-i/D) in Q1.15, from Q2.30 repeated square roots of 0.5
	function automatic exp_tab_t build_exp_table();
		exp_tab_t tab;
		logic [63:0] roots [31];
		logic [63:0] f;
		logic [63:0] r;
		logic [63:0] rr;
		roots[0] = 64'd1 << 29;
		for (int k = 1; k <= 30; k++) begin
			roots[k] = isqrt64(roots[k-1] << 30);
		end
		for (int i = 0; i < EXP_TABLE_DEPTH; i++) begin
			f = (64'(i) << 30) / EXP_TABLE_DEPTH;
			r = 64'd1 << 30;
			for (int k = 1; k <= 30; k++) begin
				if (f[30-k]) begin
					r = (r * roots[k]) >> 30;
				end
			end
			rr = (r + (64'd1 << 14)) >> 15;
			tab[i] = rr[15:0];
		end
		return tab;
	endfunction

	localparam exp_tab_t EXP_TABLE = build_exp_table();

endpackage

// ===== src/rcpi_ctrl.sv =====
`timescale 1ns / 1ps
module rcpi_ctrl import rcpi_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic photon_valid,
	input  logic first_photon,
	output logic photon_stall,
	output logic point_valid,
	input  logic point_stall,
	output cmd_t cmd
);

	typedef enum logic [7:0] {
		ST_IDLE = 8'b0000_0001,
		ST_ORIG = 8'b0000_0010,
		ST_DT   = 8'b0000_0100,
		ST_LOG  = 8'b0000_1000,
		ST_EXP  = 8'b0001_0000,
		ST_CHG  = 8'b0010_0000,
		ST_VMUL = 8'b0100_0000,
		ST_OUT  = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;
	logic out_valid_q;
	logic out_free;

	// output register can take a beat this cycle
	assign out_free = !out_valid_q || !point_stall;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				if (photon_valid) begin
					cmd.accept = 1'b1;
					cmd.first = first_photon;
					state_d = first_photon ? ST_ORIG : ST_DT;
				end
			end
			ST_ORIG: begin
				if (out_free) begin
					cmd.load_origin = 1'b1;
					state_d = ST_DT;
				end
			end
			ST_DT: begin
				cmd.step_dt = 1'b1;
				state_d = ST_LOG;
			end
			ST_LOG: begin
				cmd.step_log = 1'b1;
				state_d = ST_EXP;
			end
			ST_EXP: begin
				cmd.step_exp = 1'b1;
				state_d = ST_CHG;
			end
			ST_CHG: begin
				cmd.step_chg = 1'b1;
				state_d = ST_VMUL;
			end
			ST_VMUL: begin
				cmd.step_vmul = 1'b1;
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (out_free) begin
					cmd.load_result = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_origin || cmd.load_result) begin
				out_valid_q <= 1'b1;
			end else if (!point_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign photon_stall = (state_q != ST_IDLE);
	assign point_valid = out_valid_q;

endmodule

// ===== src/rcpi_dp.sv =====
`timescale 1ns / 1ps
module rcpi_dp import rcpi_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  cmd_t               cmd,
	input  logic [23:0]        decay_rate,
	input  logic signed [16:0] volt_per_photon,
	input  logic [31:0]        photon_time,
	input  logic               last_photon,
	output logic [31:0]        point_time,
	output logic signed [47:0] point_voltage,
	output logic               pulse_end
);

	logic [31:0] t_q, prev_q, charge_q;
	logic        last_q;

	// dt and rate product
	logic [31:0] dt;
	logic [55:0] xprod;
	logic [29:0] x_s1;
	logic        big_s1, big_s2;

	// log2(e) scaling
	logic [54:0] yprod;
	logic [30:0] y_s2;

	// table lookup
	logic [6:0]             n_raw;
	logic [23:0]            frac;
	logic [24+RIDX_W-1:0]   scaled;
	logic [RIDX_W-1:0]      ridx;
	logic                   wrap;
	logic [IDX_W-1:0]       idx;
	logic [7:0]             n_adj;
	logic [15:0]            factor;
	logic [15:0]            factor_s3;

	// charge update
	logic [47:0] cprod;
	logic [48:0] crnd;
	logic [33:0] cnew;
	logic [31:0] csat;

	// voltage
	logic signed [49:0] vprod_s5;
	logic signed [49:0] vrnd;

	assign dt = (t_q >= prev_q) ? (t_q - prev_q) : 32'd0;
	assign xprod = {32'd0, decay_rate} * {24'd0, dt};

	assign yprod = {25'd0, x_s1} * {30'd0, LOG2E_Q24};

	assign n_raw = y_s2[30:24];
	assign frac = y_s2[23:0];
	assign scaled = {{RIDX_W{1'b0}}, frac} * (24+RIDX_W)'(EXP_TABLE_DEPTH)
		+ (24+RIDX_W)'(1 << 23);
	assign ridx = scaled[24+RIDX_W-1:24];
	assign wrap = (ridx >= RIDX_W'(EXP_TABLE_DEPTH));
	assign idx = wrap ? '0 : ridx[IDX_W-1:0];
	assign n_adj = {1'b0, n_raw} + {7'd0, wrap};
	assign factor = (big_s2 || n_adj >= 8'd16) ? 16'd0 : (EXP_TABLE[idx] >> n_adj[3:0]);

	assign cprod = {16'd0, charge_q} * {32'd0, factor_s3};
	assign crnd = {1'b0, cprod} + 49'(1 << 14);
	assign cnew = crnd[48:15] + ONE_Q16;
	assign csat = (cnew[33:32] != 2'b00) ? 32'hFFFF_FFFF : cnew[31:0];

	// half away from zero: negative side rounds with one less
	assign vrnd = vprod_s5 + (vprod_s5[49] ? 50'sd32767 : 50'sd32768);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
			charge_q <= '0;
		end else begin
			if (cmd.accept && cmd.first) begin
				prev_q <= '0;
				charge_q <= '0;
			end else if (cmd.step_chg) begin
				prev_q <= t_q;
				charge_q <= csat;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			t_q <= photon_time;
			last_q <= last_photon;
		end
		if (cmd.step_dt) begin
			x_s1 <= xprod[41:12];
			big_s1 <= (xprod[55:42] != 14'd0);
		end
		if (cmd.step_log) begin
			y_s2 <= yprod[54:24];
			big_s2 <= big_s1;
		end
		if (cmd.step_exp) begin
			factor_s3 <= factor;
		end
		if (cmd.step_vmul) begin
			vprod_s5 <= 50'($signed({1'b0, charge_q})) * 50'(volt_per_photon);
		end
		if (cmd.load_origin) begin
			point_time <= '0;
			point_voltage <= '0;
			pulse_end <= 1'b0;
		end else if (cmd.load_result) begin
			point_time <= t_q;
			point_voltage <= {{14{vrnd[49]}}, vrnd[49:16]};
			pulse_end <= last_q;
		end
	end

endmodule

// ===== src/rc_photon_pileup_integrator_core.sv =====
`timescale 1ns / 1ps
// RC photon pileup integrator.
// Photon channel: photon_valid / photon_stall carry one photon per beat
// (arrival time in ns Q20.12, first and last pulse flags). Point channel:
// point_valid / point_stall carry signal points (time, voltage in uV,
// pulse_end). A beat moves at a clock edge with valid high and stall low.
// A photon flagged first resets time origin and charge and produces an
// origin point (time 0, volt 0) ahead of its own point; every photon gives
// one point. One photon is in flight at a time: after the accepting edge
// the sequencer walks the dependent chain rate*dt multiply, log2(e)
// multiply, exp table lookup, charge multiply and voltage multiply, and
// the point is loaded into the output register from ST_OUT; for a first
// photon the origin point is loaded from ST_ORIG before the chain. A new
// photon is taken only once the last point is loaded. The output register
// lets the next photon be accepted and worked on while a point waits; when
// the receiver stalls, the sequencer holds at the next point until it frees.
// Reset (arst_n low, asynchronous) clears time and charge, restores the
// register defaults and drops point_valid. Registers sit on an APB port at
// byte 0 (decay_rate) and 4 (volt_per_photon); write them only while idle.
module rc_photon_pileup_integrator_core import rcpi_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	// photon channel
	input  logic               photon_valid,
	output logic               photon_stall,
	input  logic [31:0]        photon_time,
	input  logic               first_photon,
	input  logic               last_photon,
	// point channel
	output logic               point_valid,
	input  logic               point_stall,
	output logic [31:0]        point_time,
	output logic signed [47:0] point_voltage,
	output logic               pulse_end,
	// config port
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	logic [23:0]        decay_rate_q;
	logic signed [16:0] volt_per_photon_q;
	logic               cfg_wr;
	cmd_t               cmd;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	// register select uses the word address bit only
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decay_rate_q <= DECAY_RATE_RST;
			volt_per_photon_q <= VOLT_PER_PHOTON_RST;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_DECAY_RATE: decay_rate_q <= pwdata[23:0];
				REG_VOLT_PER_PHOTON: volt_per_photon_q <= pwdata[16:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_DECAY_RATE: prdata = {8'd0, decay_rate_q};
			REG_VOLT_PER_PHOTON: prdata = {{15{volt_per_photon_q[16]}}, volt_per_photon_q};
			default: prdata = '0;
		endcase
	end

	rcpi_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.photon_valid (photon_valid),
		.first_photon (first_photon),
		.photon_stall (photon_stall),
		.point_valid  (point_valid),
		.point_stall  (point_stall),
		.cmd          (cmd)
	);

	rcpi_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.decay_rate      (decay_rate_q),
		.volt_per_photon (volt_per_photon_q),
		.photon_time     (photon_time),
		.last_photon     (last_photon),
		.point_time      (point_time),
		.point_voltage   (point_voltage),
		.pulse_end       (pulse_end)
	);

	// one sequencer step at a time
	a_one_step: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.accept, cmd.load_origin, cmd.step_dt, cmd.step_log,
			cmd.step_exp, cmd.step_chg, cmd.step_vmul, cmd.load_result}))
		else $error("more than one sequencer step active");

	// an accepted photon keeps the input closed in the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(photon_valid && !photon_stall) |=> photon_stall)
		else $error("photon accepted while previous still in flight");

	// the chain runs without gaps
	a_chain: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step_dt |=> cmd.step_log ##1 cmd.step_exp ##1 cmd.step_chg ##1 cmd.step_vmul)
		else $error("datapath chain broken");

	// a taken point without reload empties the output register
	a_out_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(point_valid && !point_stall && !cmd.load_origin && !cmd.load_result)
		|=> !point_valid)
		else $error("point repeated after beat");

endmodule
